@@ design/rbph_pkg.sv @@
// ----------------------------------------------------------------------------
// rbph_pkg: shared types and constants for the bounded plane hit test
// Register indexes, field widths and the per-ray data carried down the pipe.
// ----------------------------------------------------------------------------
package rbph_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X     = 3'd0,
    REG_NORMAL_Y     = 3'd1,
    REG_NORMAL_Z     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_BOUND_MIN_X  = 3'd4,
    REG_BOUND_MAX_X  = 3'd5,
    REG_BOUND_MIN_Z  = 3'd6,
    REG_BOUND_MAX_Z  = 3'd7
  } cfg_reg_t;

  localparam logic signed [DATA_W-1:0] NORMAL_Y_RST = 32'sd65536;

  typedef struct packed {
    logic signed [DATA_W-1:0] ox;
    logic signed [DATA_W-1:0] oz;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vz;
    logic signed [DATA_W-1:0] tlo;
    logic signed [DATA_W-1:0] thi;
  } ray_side_t;

endpackage

@@ design/ray_bounded_plane_hit_test_unit.sv @@
// ----------------------------------------------------------------------------
// ray_bounded_plane_hit_test_unit: ray against bounded plane hit test
// Fixed-point ray/plane intersection with a pipelined restoring divider and
// rectangle and parameter range checks; one result per ray.
// ----------------------------------------------------------------------------
// Throughput: one ray per cycle while the output is not stalled; the 32-stage
// divider takes one quotient bit per stage, so a new ray can enter every cycle.
// Reset: rst clears all valid bits and loads the register reset values
// (normal_y = 1.0, all others 0).
module ray_bounded_plane_hit_test_unit #(
  parameter int FRAC_BITS = rbph_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rbph_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbph_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rbph_pkg::DATA_W-1:0]  origin_x,
  input  logic signed [rbph_pkg::DATA_W-1:0]  origin_y,
  input  logic signed [rbph_pkg::DATA_W-1:0]  origin_z,
  input  logic signed [rbph_pkg::DATA_W-1:0]  dir_x,
  input  logic signed [rbph_pkg::DATA_W-1:0]  dir_y,
  input  logic signed [rbph_pkg::DATA_W-1:0]  dir_z,
  input  logic signed [rbph_pkg::DATA_W-1:0]  t_lower,
  input  logic signed [rbph_pkg::DATA_W-1:0]  t_upper,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit
);
  import rbph_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int PW     = PROD_W - FRAC_BITS;
  localparam int DW     = PW + 2;
  localparam int NW     = PW + 3;
  localparam int MW     = NW;
  localparam int SH     = DATA_W - FRAC_BITS;
  localparam int STEPS  = DATA_W;
  localparam int XW     = PW + 1;

  // configuration registers
  logic signed [DATA_W-1:0] normal_x, normal_y, normal_z, plane_offset;
  logic signed [DATA_W-1:0] bound_min_x, bound_max_x, bound_min_z, bound_max_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x     <= '0;
      normal_y     <= NORMAL_Y_RST;
      normal_z     <= '0;
      plane_offset <= '0;
      bound_min_x  <= '0;
      bound_max_x  <= '0;
      bound_min_z  <= '0;
      bound_max_z  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NORMAL_X:     normal_x     <= cfg_data;
        REG_NORMAL_Y:     normal_y     <= cfg_data;
        REG_NORMAL_Z:     normal_z     <= cfg_data;
        REG_PLANE_OFFSET: plane_offset <= cfg_data;
        REG_BOUND_MIN_X:  bound_min_x  <= cfg_data;
        REG_BOUND_MAX_X:  bound_max_x  <= cfg_data;
        REG_BOUND_MIN_Z:  bound_min_z  <= cfg_data;
        REG_BOUND_MAX_Z:  bound_max_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the whole pipe while the result is stalled
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: products
  logic                     v1;
  logic signed [PROD_W-1:0] pvx, pvy, pvz, pox, poy, poz;
  ray_side_t                side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pvx   <= normal_x * dir_x;
      pvy   <= normal_y * dir_y;
      pvz   <= normal_z * dir_z;
      pox   <= normal_x * origin_x;
      poy   <= normal_y * origin_y;
      poz   <= normal_z * origin_z;
      side1 <= '{ox: origin_x, oz: origin_z, vx: dir_x, vz: dir_z,
                 tlo: t_lower, thi: t_upper};
    end
  end

  // stage 2: scaled sums
  logic signed [PW-1:0] fvx, fvy, fvz, fox, foy, foz;
  assign fvx = PW'(pvx >>> FRAC_BITS);
  assign fvy = PW'(pvy >>> FRAC_BITS);
  assign fvz = PW'(pvz >>> FRAC_BITS);
  assign fox = PW'(pox >>> FRAC_BITS);
  assign foy = PW'(poy >>> FRAC_BITS);
  assign foz = PW'(poz >>> FRAC_BITS);

  logic                 v2;
  logic signed [DW-1:0] den;
  logic signed [NW-1:0] num;
  ray_side_t            side2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den   <= DW'(fvx) + DW'(fvy) + DW'(fvz);
      num   <= -(NW'(fox) + NW'(foy) + NW'(foz) + NW'(plane_offset));
      side2 <= side1;
    end
  end

  // stage 3: magnitudes, sign and overflow, then the divider
  logic [MW-1:0] num_mag, den_mag;
  logic          ovf;
  assign num_mag = (num < 0) ? MW'(-num) : MW'(num);
  assign den_mag = (den < 0) ? MW'(-den) : MW'(den);
  assign ovf     = {{SH{1'b0}}, num_mag} >= {den_mag, {SH{1'b0}}};

  logic              dv_v    [0:STEPS];
  logic [MW-1:0]     dv_rem  [0:STEPS];
  logic [MW-1:0]     dv_dm   [0:STEPS];
  logic [DATA_W-1:0] dv_low  [0:STEPS];
  logic [DATA_W-1:0] dv_q    [0:STEPS];
  logic              dv_neg  [0:STEPS];
  logic              dv_kill [0:STEPS];
  ray_side_t         dv_side [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]  <= num_mag >> SH;
      dv_dm[0]   <= den_mag;
      dv_low[0]  <= {num_mag[SH-1:0], {FRAC_BITS{1'b0}}};
      dv_q[0]    <= '0;
      dv_neg[0]  <= (num < 0) != (den < 0);
      dv_kill[0] <= (den == 0) || ovf;
      dv_side[0] <= side2;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    logic [MW:0] rs, diff;
    logic        ge;
    assign rs   = {dv_rem[k], dv_low[k][DATA_W-1]};
    assign ge   = rs >= {1'b0, dv_dm[k]};
    assign diff = rs - {1'b0, dv_dm[k]};

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (en) dv_v[k+1] <= dv_v[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k+1]  <= ge ? diff[MW-1:0] : rs[MW-1:0];
        dv_dm[k+1]   <= dv_dm[k];
        dv_low[k+1]  <= {dv_low[k][DATA_W-2:0], 1'b0};
        dv_q[k+1]    <= {dv_q[k][DATA_W-2:0], ge};
        dv_neg[k+1]  <= dv_neg[k];
        dv_kill[k+1] <= dv_kill[k];
        dv_side[k+1] <= dv_side[k];
      end
    end
  end

  // stage 4: signed t and range check
  logic signed [DATA_W:0] t_full;
  assign t_full = dv_neg[STEPS] ? -$signed({1'b0, dv_q[STEPS]})
                                :  $signed({1'b0, dv_q[STEPS]});

  logic                     v4, ok4;
  logic signed [DATA_W-1:0] t4;
  ray_side_t                side4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= dv_v[STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok4   <= !dv_kill[STEPS] && (t_full >= (DATA_W+1)'(dv_side[STEPS].tlo))
               && (t_full <= (DATA_W+1)'(dv_side[STEPS].thi));
      t4    <= t_full[DATA_W-1:0];
      side4 <= dv_side[STEPS];
    end
  end

  // stage 5: hit point products
  logic                     v5, ok5;
  logic signed [PROD_W-1:0] ptx, ptz;
  logic signed [DATA_W-1:0] ox5, oz5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok5 <= ok4;
      ptx <= t4 * side4.vx;
      ptz <= t4 * side4.vz;
      ox5 <= side4.ox;
      oz5 <= side4.oz;
    end
  end

  // stage 6: bounds check into the output register
  logic signed [XW-1:0] hx, hz;
  logic                 in_x, in_z;
  assign hx   = XW'(ox5) + XW'(PW'(ptx >>> FRAC_BITS));
  assign hz   = XW'(oz5) + XW'(PW'(ptz >>> FRAC_BITS));
  assign in_x = (hx >= XW'(bound_min_x)) && (hx <= XW'(bound_max_x));
  assign in_z = (hz >= XW'(bound_min_z)) && (hz <= XW'(bound_max_z));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) hit <= ok5 && in_x && in_z;
  end

endmodule

@@ design/rbph_checker.sv @@
// ----------------------------------------------------------------------------
// rbph_checker: port-level checks for the hit test unit
// Watches handshakes and reset behaviour on the top-level ports.
// ----------------------------------------------------------------------------
module rbph_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [rbph_pkg::DATA_W-1:0]       origin_x,
  input logic                              hit
);
  import rbph_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit)))
    else $error("stalled result changed");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(origin_x)))
    else $error("stalled input transaction changed");

endmodule

bind ray_bounded_plane_hit_test_unit rbph_checker u_rbph_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .origin_x  (origin_x),
  .hit       (hit)
);

@@ tb/ray_bounded_plane_hit_test_unit_tb.sv @@
// ----------------------------------------------------------------------------
// ray_bounded_plane_hit_test_unit_tb: self-checking bench for the hit test
// Drives rays under several plane and rectangle settings, predicts each hit
// flag in fixed point and compares it against every output transaction, with
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module ray_bounded_plane_hit_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbph_pkg::*;

  localparam int FB      = FRAC_BITS_DEF;
  localparam int N_RAND  = 1430;
  localparam int SETTLE  = 60;
  localparam logic signed [31:0] ONE  = 32'sd65536;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  typedef struct {
    logic signed [31:0] ox, oy, oz, vx, vy, vz, tlo, thi;
  } ray_t;

  typedef struct {
    ray_t r;
    bit   known;
    bit   hit;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [31:0] t_lower = '0, t_upper = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;

  logic signed [31:0] plane_reg [8];
  bit hit_queue [$];
  int mismatches = 0;
  int hits_seen = 0;
  int rays_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;

  ray_bounded_plane_hit_test_unit u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #400ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint floor_q(longint p);
    return p >>> FB;
  endfunction

  function automatic bit predict_hit(ray_t r);
    longint nx, ny, nz, den, num, t, x, z;
    longint unsigned nm, dm, q;
    nx = plane_reg[REG_NORMAL_X];
    ny = plane_reg[REG_NORMAL_Y];
    nz = plane_reg[REG_NORMAL_Z];
    den = floor_q(nx * r.vx) + floor_q(ny * r.vy) + floor_q(nz * r.vz);
    if (den == 0) return 1'b0;
    num = -(floor_q(nx * r.ox) + floor_q(ny * r.oy) + floor_q(nz * r.oz)
            + longint'(plane_reg[REG_PLANE_OFFSET]));
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -den : den;
    q = nm / dm;
    if ((q >> (32 - FB)) != 0) begin
      t = 64'd1 << 32;
    end else begin
      t = longint'((nm << FB) / dm);
    end
    if ((num < 0) != (den < 0)) t = -t;
    if (t < r.tlo || t > r.thi) return 1'b0;
    x = r.ox + floor_q(t * r.vx);
    z = r.oz + floor_q(t * r.vz);
    if (x < plane_reg[REG_BOUND_MIN_X] || x > plane_reg[REG_BOUND_MAX_X]) return 1'b0;
    if (z < plane_reg[REG_BOUND_MIN_Z] || z > plane_reg[REG_BOUND_MAX_Z]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic signed [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    plane_reg[idx] = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_plane(logic signed [31:0] nx, ny, nz, d, x0, x1, z0, z1);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_PLANE_OFFSET, d);
    write_reg(REG_BOUND_MIN_X, x0);
    write_reg(REG_BOUND_MAX_X, x1);
    write_reg(REG_BOUND_MIN_Z, z0);
    write_reg(REG_BOUND_MAX_Z, z1);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (hit_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // one transaction; valid stays high across back-to-back rays
  task automatic send_ray(ray_t r, bit known, bit want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
    dir_x <= r.vx; dir_y <= r.vy; dir_z <= r.vz;
    t_lower <= r.tlo; t_upper <= r.thi;
    do @(posedge clk); while (in_stall);
    if (known && predict_hit(r) != want) begin
      $display("directed row disagrees with predictor: expected %0b", want);
      mismatches++;
    end
    hit_queue.push_back(known ? want : predict_hit(r));
  endtask

  task automatic end_burst;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return SMAX;
      1: return SMIN;
      2: return $urandom_range(8, 0) * ONE - 4 * ONE;
      3: return $signed($urandom_range(32'h3ffff)) - 32'sh1ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic ray_t aimed_ray();
    ray_t r;
    r.ox = $signed($urandom_range(32'h7ffff)) - 32'sh3ffff;
    r.oy = $signed($urandom_range(32'h7ffff)) + ONE;
    r.oz = $signed($urandom_range(32'h7ffff)) - 32'sh3ffff;
    r.vx = $signed($urandom_range(32'h1ffff)) - ONE;
    r.vy = -$signed($urandom_range(32'h1ffff, 32'h1000));
    r.vz = $signed($urandom_range(32'h1ffff)) - ONE;
    r.tlo = $urandom_range(3) == 0 ? SMIN : 32'sd0;
    r.thi = $urandom_range(3) == 0 ? SMAX : $signed($urandom_range(32'h7fffff));
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.ox = rand_word(); r.oy = rand_word(); r.oz = rand_word();
    r.vx = rand_word(); r.vy = rand_word(); r.vz = rand_word();
    r.tlo = rand_word(); r.thi = rand_word();
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (hit_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction, hit=%0b", hit);
        end else begin
          bit want;
          want = hit_queue.pop_front();
          rays_checked++;
          hits_seen += hit;
          if (hit !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hit mismatch on ray %0d: expected %0b actual %0b",
                       rays_checked, want, hit);
          end
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    int hold;
    wait (!rst);
    wait (send_idle_pct == 0 && recv_idle_pct == 0 && hit_queue.size() > 20);
    @(posedge clk);
    hold_off <= 1'b1;
    for (hold = 0; hold < 150; hold++) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    ray_row_t rows [$];
    ray_t r;
    int phase, i;
    plane_reg[0] = 0; plane_reg[1] = NORMAL_Y_RST; plane_reg[2] = 0; plane_reg[3] = 0;
    for (i = 4; i < 8; i++) plane_reg[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rays, most straight down, onto y=0; reset bounds are the single point (0,0)
    rows.push_back('{'{0, ONE, 0, 0, -ONE, 0, 0, SMAX}, 1, 1});
    rows.push_back('{'{ONE, ONE, 0, 0, -ONE, 0, 0, SMAX}, 1, 0});
    rows.push_back('{'{0, ONE, 0, ONE, 0, 0, SMIN, SMAX}, 1, 0});
    rows.push_back('{'{0, ONE, 0, 0, -ONE, 0, 2 * ONE, SMAX}, 1, 0});
    rows.push_back('{'{0, ONE, 0, 0, -ONE, 0, ONE, ONE}, 1, 1});
    rows.push_back('{'{0, ONE, 0, 0, -ONE, 0, SMAX, SMIN}, 1, 0});
    rows.push_back('{'{0, SMAX, 0, 0, 1, 0, SMIN, SMAX}, 1, 0});
    rows.push_back('{'{0, 0, 0, 0, SMIN, 0, SMIN, SMAX}, 1, 1});
    rows.push_back('{'{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMAX}, 0, 0});
    rows.push_back('{'{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMIN, SMAX}, 0, 0});
    rows.push_back('{'{0, -ONE, 0, 0, ONE, 0, 0, SMAX}, 1, 1});
    rows.push_back('{'{0, ONE, 0, 0, -ONE, 0, SMIN, 0}, 1, 0});
    rows.push_back('{'{0, ONE, 0, 0, 1, 0, SMIN, SMAX}, 1, 0});
    foreach (rows[k]) send_ray(rows[k].r, rows[k].known, rows[k].hit);
    end_burst();
    drain();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_plane(0, ONE, 0, 0, -4 * ONE, 4 * ONE, -4 * ONE, 4 * ONE);
        1: load_plane(SMIN, SMIN, SMIN, SMIN, SMIN, SMAX, SMIN, SMAX);
        2: load_plane(SMAX, SMAX, SMAX, SMAX, SMIN, SMAX, SMIN, SMAX);
        3: load_plane(ONE / 4, ONE, -ONE / 8, ONE / 2, -2 * ONE, 3 * ONE, -ONE, 5 * ONE);
        4: load_plane(0, ONE, 0, 0, ONE, -ONE, SMIN, SMAX);
        default: load_plane($urandom, $urandom, $urandom, $urandom,
                            -8 * ONE, 8 * ONE, -8 * ONE, 8 * ONE);
      endcase
      for (i = 0; i < N_RAND / 6; i++) begin
        send_idle_pct = i < N_RAND / 18 ? 26 : (i < N_RAND / 9 ? 48 : 0);
        recv_idle_pct = i < N_RAND / 18 ? 48 : (i < N_RAND / 9 ? 26 : 0);
        r = ($urandom_range(99) < 70) ? aimed_ray() : noise_ray();
        send_ray(r, 0, 0);
      end
      end_burst();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain();
    end

    $display("%0d rays checked over 7 plane settings, %0d hits, idling and a long hold-off",
             rays_checked, hits_seen);
    if (mismatches == 0 && hit_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, hit_queue.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rbph_pkg.sv
design/ray_bounded_plane_hit_test_unit.sv
design/rbph_checker.sv
tb/ray_bounded_plane_hit_test_unit_tb.sv
